### hw/rtl/additive_harmonic_oscillator_defines.svh
// Assertion macros shared by the additive harmonic oscillator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ADDITIVE_HARMONIC_OSCILLATOR_DEFINES_SVH
`define ADDITIVE_HARMONIC_OSCILLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AHO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oscillator check failed");

// The consequent must hold in the cycle after the antecedent.
`define AHO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oscillator check failed");

`endif

### hw/rtl/aho_pkg.sv
// Shared constants, types and the sine table of the additive harmonic oscillator.
// Depends on nothing; imported by every module of the block.
package aho_pkg;

  // Sizing of the harmonic bank and the sine table.
  localparam int MAX_HARMONICS   = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int QUARTER         = TABLE_SIZE >> 2;

  localparam int HIDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int HCNT_W = $clog2(MAX_HARMONICS + 1);

  // Field widths.
  localparam int PHASE_W   = 24;
  localparam int AMP_W     = 16;
  localparam int SINE_W    = 16;
  localparam int SAMPLE_W  = 22;
  localparam int SPREAD_W  = 16;
  localparam int NH_W      = 6;

  // Multiplier of a spread by the harmonic index, plus an offset.
  localparam int M_W       = SPREAD_W + HIDX_W + 1;
  localparam int MUL_X_W   = PHASE_W + 1;
  localparam int MUL_Y_W   = M_W + 1;
  localparam int MUL_P_W   = MUL_X_W + MUL_Y_W;
  localparam int ACC_W     = 32 + HIDX_W;

  // Amplitude divider.
  localparam int DIV_W     = 24;
  localparam int DEN_W     = M_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Port widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_SPREAD_A      = 3'd1,
    CFG_SPREAD_B      = 3'd2,
    CFG_NUM_HARMONICS = 3'd3,
    CFG_BASE_STEP     = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic                mode;
    logic [SPREAD_W-1:0] spread_a;
    logic [SPREAD_W-1:0] spread_b;
    logic [NH_W-1:0]     num_harmonics;
    logic [PHASE_W-1:0]  base_step;
  } aho_cfg_t;

  // Control from the top level to the engine.
  typedef struct packed {
    logic start;
    logic restart;
    logic take;
  } aho_ctl_t;

  // Status from the engine to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } aho_sts_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_resp_t;

  // Sine table, Q1.15, built from a Q30 Taylor series over a quarter wave.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SINE_W-1:0] sine_rom_t [TABLE_SIZE];

  function automatic logic [63:0] taylor_next(input logic [63:0] term,
                                              input logic [63:0] x);
    return (((term * x) >> 30) * x) >> 30;
  endfunction

  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x    = (HALF_PI_Q30 * r + 64'(QUARTER / 2)) / QUARTER;
    term = x;
    acc  = signed'(x);
    term = taylor_next(term, x) / 6;
    acc  = acc - signed'(term);
    term = taylor_next(term, x) / 20;
    acc  = acc + signed'(term);
    term = taylor_next(term, x) / 42;
    acc  = acc - signed'(term);
    term = taylor_next(term, x) / 72;
    acc  = acc + signed'(term);
    term = taylor_next(term, x) / 110;
    acc  = acc - signed'(term);
    term = taylor_next(term, x) / 156;
    acc  = acc + signed'(term);
    term = taylor_next(term, x) / 210;
    acc  = acc - signed'(term);
    if (acc < 0) begin
      acc = '0;
    end
    v = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    logic [SINE_W-1:0] s;
    int                q;
    int                r;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      q = k / QUARTER;
      r = k % QUARTER;
      s = ((q & 1) != 0) ? quarter_sine(64'(QUARTER - r)) : quarter_sine(64'(r));
      rom[k] = ((q & 2) != 0) ? -signed'(s) : signed'(s);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### hw/rtl/aho_divider.sv
// Restoring divider, one quotient bit per cycle, for the harmonic amplitudes.
// Depends on aho_pkg for widths and the request and response structs.
module aho_divider
  import aho_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DIV_W-1:0]     quo;

  logic [DEN_W:0]       shifted;
  logic [DEN_W+1:0]     diff;
  logic                 neg;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
    neg     = diff[DEN_W+1];
  end

  // Iteration control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= neg ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], ~neg};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign resp.busy = busy;
  assign resp.done = done;
  assign resp.quot = quo;

endmodule

### hw/rtl/aho_engine.sv
// Sequencer, harmonic memories, sine table and shared multiplier of the oscillator.
// Depends on aho_pkg, the assertion macros and aho_divider.
`include "additive_harmonic_oscillator_defines.svh"

module aho_engine
  import aho_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  aho_ctl_t                   ctl,
  input  aho_cfg_t                   cfg,
  output aho_sts_t                   sts,
  output logic signed [SAMPLE_W-1:0] sample
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_RMA,
    E_RMB,
    E_RMS,
    E_RDIV,
    E_RUN,
    E_ROUND,
    E_DONE
  } state_t;

  state_t state;

  // Per-harmonic memories.
  logic [PHASE_W-1:0] phase_mem [MAX_HARMONICS];
  logic [PHASE_W-1:0] step_mem  [MAX_HARMONICS];
  logic [AMP_W-1:0]   amp_mem   [MAX_HARMONICS];

  logic [HCNT_W-1:0]          h_cnt;
  logic [HIDX_W-1:0]          h_idx;
  logic [HIDX_W-1:0]          idx1;
  logic                       framed;
  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic [M_W-1:0]             a_i;
  logic signed [MUL_P_W-1:0]  prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] sample_q;

  logic [PHASE_W-1:0]         phase_q;
  logic [PHASE_W-1:0]         step_q;
  logic [AMP_W-1:0]           amp_q;
  logic [AMP_W-1:0]           amp2;
  logic signed [SINE_W-1:0]   sine_q;

  logic                       rd_go;
  logic                       active;
  logic                       coef_we;
  logic [M_W-1:0]             m_val;
  logic [DEN_W-1:0]           d_val;
  logic                       mul_en;
  logic signed [MUL_X_W-1:0]  mul_x;
  logic signed [MUL_Y_W-1:0]  mul_y;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]    rnd_sum;
  logic signed [ACC_W-1:0]    rnd;
  logic [ACC_W-SAMPLE_W:0]    rnd_hi;
  logic                       rnd_fits;
  logic [SAMPLE_W-1:0]        rnd_sat;

  div_req_t  div_req;
  div_resp_t div_resp;

  assign h_idx   = h_cnt[HIDX_W-1:0];
  assign rd_go   = (state == E_RUN) && (h_cnt != HCNT_W'(MAX_HARMONICS));
  assign active  = int'(h_cnt) < int'(cfg.num_harmonics);
  assign coef_we = (state == E_RDIV) && div_resp.done;

  // Frequency multiplier and amplitude denominator of the current harmonic.
  always_comb begin
    m_val = cfg.mode ? (a_i + M_W'(cfg.spread_b)) : (prod[M_W-1:0] + M_W'(256));
    d_val = a_i + DEN_W'(256);
  end

  // Amplitude division: round(2^23 / d), that is floor((2^23 + d/2) / d).
  always_comb begin
    div_req.start = (state == E_RMS);
    div_req.num   = DIV_W'(2 ** 23) + DIV_W'(d_val >> 1);
    div_req.den   = d_val;
  end

  aho_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // Shared multiplier: index products and steps at restart, sine times amplitude per tick.
  always_comb begin
    mul_en = 1'b1;
    mul_x  = '0;
    mul_y  = '0;
    case (state)
      E_RMA: begin
        mul_x = {{(MUL_X_W-SPREAD_W){1'b0}}, cfg.spread_a};
        mul_y = {{(MUL_Y_W-HCNT_W){1'b0}}, h_cnt};
      end
      E_RMB: begin
        mul_x = {{(MUL_X_W-SPREAD_W){1'b0}}, cfg.spread_b};
        mul_y = {{(MUL_Y_W-HCNT_W){1'b0}}, h_cnt};
      end
      E_RMS: begin
        mul_x = {1'b0, cfg.base_step};
        mul_y = {1'b0, m_val};
      end
      E_RUN: begin
        mul_x = {{(MUL_X_W-SINE_W){sine_q[SINE_W-1]}}, sine_q};
        mul_y = {{(MUL_Y_W-AMP_W){1'b0}}, amp2};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // Rounding to Q6.15 and saturation of the finished sum.
  always_comb begin
    rnd_sum  = acc + ACC_W'(2 ** 14);
    rnd      = rnd_sum >>> 15;
    rnd_hi   = rnd[ACC_W-1:SAMPLE_W-1];
    rnd_fits = (&rnd_hi) || !(|rnd_hi);
    rnd_sat  = rnd[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  end

  // Harmonic memories: coefficient writes at restart, phase write-back per tick.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      step_mem[h_idx] <= active ? prod[PHASE_W+7:8] : '0;
      amp_mem[h_idx]  <= active ? div_resp.quot[AMP_W-1:0] : '0;
    end
    if (coef_we) begin
      phase_mem[h_idx] <= '0;
    end else if (v1 && framed) begin
      phase_mem[idx1] <= phase_q + step_q;
    end
    if (rd_go) begin
      phase_q <= phase_mem[h_idx];
      step_q  <= step_mem[h_idx];
      amp_q   <= amp_mem[h_idx];
    end
  end

  // Sine table read, registered.
  always_ff @(posedge clk) begin
    sine_q <= SINE_ROM[phase_q[PHASE_W-1 -: SINE_TABLE_BITS]];
    amp2   <= amp_q;
  end

  // Sequencer with the accumulation pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      framed <= 1'b0;
      h_cnt  <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      acc    <= '0;
    end else begin
      if (mul_en) begin
        prod <= mul_p;
      end
      v1 <= rd_go;
      v2 <= v1;
      v3 <= v2;
      if (rd_go) begin
        idx1  <= h_idx;
        h_cnt <= h_cnt + 1'b1;
      end
      if (v3 && framed) begin
        acc <= acc + signed'(prod[ACC_W-1:0]);
      end
      unique case (state)
        E_IDLE: begin
          if (ctl.start) begin
            acc   <= '0;
            h_cnt <= '0;
            if (ctl.restart) begin
              framed <= 1'b1;
              state  <= E_RMA;
            end else begin
              state <= E_RUN;
            end
          end
        end
        E_RMA: begin
          state <= E_RMB;
        end
        E_RMB: begin
          a_i   <= prod[M_W-1:0];
          state <= E_RMS;
        end
        E_RMS: begin
          state <= E_RDIV;
        end
        E_RDIV: begin
          if (div_resp.done) begin
            if (h_cnt == HCNT_W'(MAX_HARMONICS - 1)) begin
              h_cnt <= '0;
              state <= E_RUN;
            end else begin
              h_cnt <= h_cnt + 1'b1;
              state <= E_RMA;
            end
          end
        end
        E_RUN: begin
          if (!rd_go && !v1 && !v2 && !v3) begin
            state <= E_ROUND;
          end
        end
        E_ROUND: begin
          sample_q <= rnd_fits ? rnd[SAMPLE_W-1:0] : rnd_sat;
          state    <= E_DONE;
        end
        E_DONE: begin
          if (ctl.take) begin
            state <= E_IDLE;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign sts.idle = (state == E_IDLE);
  assign sts.done = (state == E_DONE);
  assign sample   = sample_q;

  // The divider is quiet whenever the engine can take a new item.
  `AHO_ASSERT_IMPLY(a_idle_div_quiet, clk, rst, state == E_IDLE, !div_resp.busy)
  // A quotient only arrives while the sequencer waits for it.
  `AHO_ASSERT_IMPLY(a_div_done_wait, clk, rst, div_resp.done, state == E_RDIV)
  // The accumulation pipeline holds items only during the tick pass.
  `AHO_ASSERT_IMPLY(a_pipe_in_run, clk, rst, v1 || v2 || v3, state == E_RUN)
  // A finished sample that is not taken stays unchanged.
  `AHO_ASSERT_NEXT(a_done_hold, clk, rst, sts.done && !ctl.take, sts.done && $stable(sample))

endmodule

### hw/rtl/additive_harmonic_oscillator.sv
// Additive harmonic oscillator: one saturated sum of weighted sines per input transfer.
// A tick without restart does one table read and one multiply-accumulate per harmonic in the engine;
// the engine accepts no new tick until its sample has been taken by the output register.
// A restart tick first computes the step and amplitude of every harmonic, using the bit-serial
// amplitude divider. Synchronous reset clears all control state; amplitudes read as zero until a restart.
module additive_harmonic_oscillator
  import aho_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
  // Output stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [21:0] sample, [23:22] zero
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  aho_cfg_t                   cfg_q;
  aho_ctl_t                   ctl;
  aho_sts_t                   sts;
  logic signed [SAMPLE_W-1:0] eng_sample;
  logic [SAMPLE_W-1:0]        out_sample;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.mode          <= 1'b0;
      cfg_q.spread_a      <= SPREAD_W'(256);
      cfg_q.spread_b      <= SPREAD_W'(256);
      cfg_q.num_harmonics <= NH_W'(1);
      cfg_q.base_step     <= PHASE_W'(262144);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:          cfg_q.mode          <= cfg_data[0];
        CFG_SPREAD_A:      cfg_q.spread_a      <= cfg_data[SPREAD_W-1:0];
        CFG_SPREAD_B:      cfg_q.spread_b      <= cfg_data[SPREAD_W-1:0];
        CFG_NUM_HARMONICS: cfg_q.num_harmonics <= cfg_data[NH_W-1:0];
        CFG_BASE_STEP:     cfg_q.base_step     <= cfg_data[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Engine handshake: a transfer starts the engine, the output register takes its sample.
  assign s_tready    = sts.idle;
  assign ctl.start   = s_tvalid && s_tready;
  assign ctl.restart = s_tdata[0];
  assign ctl.take    = sts.done && (!m_tvalid || m_tready);

  aho_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg_q),
    .sts    (sts),
    .sample (eng_sample)
  );

  // Output register separating the engine from the downstream side.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.take) begin
        m_tvalid   <= 1'b1;
        out_sample <= eng_sample;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-SAMPLE_W){1'b0}}, out_sample};

endmodule
